[sv/tuning_byte_receiver_defines.svh]
// Assertion macros shared by the tuning byte receiver RTL.
`ifndef TUNING_BYTE_RECEIVER_DEFINES_SVH
`define TUNING_BYTE_RECEIVER_DEFINES_SVH

// Check a condition at every clock edge outside reset.
`define TBR_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a condition in one cycle implies another in the next cycle.
`define TBR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[sv/tbr_pkg.sv]
// Types, constants and helpers shared by the tuning byte receiver modules.
package tbr_pkg;

  localparam int MAX_VARS  = 16;
  localparam int CODE_W    = 3;
  localparam int CNT_W     = $clog2(MAX_VARS + 1);
  localparam int IDX_W     = $clog2(MAX_VARS);
  localparam int TABLE_W   = MAX_VARS * CODE_W;
  localparam int OFS_W     = 2;
  localparam int BYTE_W    = 8;
  localparam int CFG_IDX_W = 1;
  localparam int TDATA_W   = 24;

  localparam logic [BYTE_W-1:0] BYTE_ACK   = 8'hFF;
  localparam logic [BYTE_W-1:0] BYTE_START = 8'hFE;
  localparam logic [BYTE_W-1:0] BYTE_STOP  = 8'h00;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_VARIABLE_COUNT = 1'b0,
    CFG_TYPE_TABLE     = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic             tuning_active;
    logic [CNT_W-1:0] current_var;
    logic [OFS_W-1:0] current_byte;
    logic             stop_state;
  } tbr_state_t;

  typedef struct packed {
    logic              write_valid;
    logic [IDX_W-1:0]  var_index;
    logic [OFS_W-1:0]  byte_offset;
    logic [BYTE_W-1:0] write_data;
    logic              ack_seen;
    logic              motor_off;
    logic              stop_flag;
    logic              tuning_busy;
  } tbr_result_t;

  // Last byte offset of a variable from its type code: 1, 2 or 4 bytes.
  function automatic logic [OFS_W-1:0] last_offset(input logic [CODE_W-1:0] code);
    logic [OFS_W-1:0] ofs;
    if (code[2]) begin
      ofs = 2'd3;
    end else if (code[1]) begin
      ofs = 2'd1;
    end else begin
      ofs = 2'd0;
    end
    return ofs;
  endfunction

  // Clamp a written count to the table size.
  function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] cnt);
    logic [CNT_W-1:0] lim;
    lim = CNT_W'(MAX_VARS);
    return (cnt > lim) ? lim : cnt;
  endfunction

endpackage

[sv/tbr_step.sv]
// Next-state and result logic for one received byte.
module tbr_step (
  input  tbr_pkg::tbr_state_t                   state,
  input  logic [tbr_pkg::BYTE_W-1:0]            rx_byte,
  input  logic [tbr_pkg::CNT_W-1:0]             var_count,
  input  logic [tbr_pkg::TABLE_W-1:0]           type_table,
  output tbr_pkg::tbr_state_t                   state_nxt,
  output tbr_pkg::tbr_result_t                  result
);
  import tbr_pkg::*;

  logic [MAX_VARS-1:0][CODE_W-1:0] codes;
  logic [CODE_W-1:0]               cur_code;
  logic [OFS_W-1:0]                cur_last;

  assign codes    = type_table;
  assign cur_code = codes[state.current_var[IDX_W-1:0]];
  assign cur_last = last_offset(cur_code);

  always_comb begin
    state_nxt = state;
    result    = '0;
    if (state.tuning_active) begin
      if (state.current_var >= var_count) begin
        // count dropped to or below the run position: end the run, write nothing
        state_nxt.tuning_active = 1'b0;
      end else begin
        result.write_valid = 1'b1;
        result.var_index   = state.current_var[IDX_W-1:0];
        result.byte_offset = state.current_byte;
        result.write_data  = rx_byte;
        if (state.current_byte >= cur_last) begin
          state_nxt.current_var  = state.current_var + CNT_W'(1);
          state_nxt.current_byte = '0;
        end else begin
          state_nxt.current_byte = state.current_byte + OFS_W'(1);
        end
        if (state_nxt.current_var >= var_count) begin
          state_nxt.tuning_active = 1'b0;
        end
      end
    end else if (rx_byte == BYTE_ACK) begin
      result.ack_seen = 1'b1;
    end else if (rx_byte == BYTE_START) begin
      state_nxt.current_var   = '0;
      state_nxt.current_byte  = '0;
      state_nxt.tuning_active = (var_count != '0);
    end else if (rx_byte == BYTE_STOP) begin
      result.motor_off     = 1'b1;
      state_nxt.stop_state = ~state.stop_state;
    end
    result.stop_flag   = state_nxt.stop_state;
    result.tuning_busy = state_nxt.tuning_active;
  end

endmodule

[sv/tuning_byte_receiver.sv]
// Top level of the tuning byte receiver: stream ports, config and pipeline.
//
// Usage: each request on the in_ channel carries one received serial byte in
// in_tdata[7:0]. Outside a tuning run, 255 reports an acknowledge, 254 starts
// a run and 0 stops the motor and toggles the stop flag; during a run every
// byte is written into the next byte of the current variable.
// Every input request yields exactly one request on the out_ channel, in order.
// out_tuser[0] is write_valid; out_tdata carries the decoded write and status.
// The byte enters the input register at the input accept edge and moves into
// the result register, which drives out_tvalid, once that register is free.
// Throughput: one byte per cycle while out_tready stays high, set by the
// single state update between the input and result registers.
// The cfg_ channel writes variable_count (index 0) and type_table (index 1);
// cfg_ready is always high. Write configuration only while the block is idle.
// Reset (rst_n low, synchronous) ends any run, clears the stop flag, the
// config registers and both pipeline stages. When the receiver drops
// out_tready, the result register holds, the input register holds behind it,
// and in_tready falls only once both are full.
`include "tuning_byte_receiver_defines.svh"

module tuning_byte_receiver (
  input  logic                              clk,
  input  logic                              rst_n,
  // input byte stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [7:0]                        in_tdata,   // [7:0] rx_byte
  // result stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [tbr_pkg::TDATA_W-1:0]       out_tdata,  // [3:0] var_index, [5:4] byte_offset,
                                                        // [13:6] write_data, [14] ack_seen,
                                                        // [15] motor_off, [16] stop_flag,
                                                        // [17] tuning_busy, [23:18] zero
  output logic [0:0]                        out_tuser,  // [0] write_valid
  // configuration writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tbr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tbr_pkg::TABLE_W-1:0]       cfg_data
);
  import tbr_pkg::*;

  // configuration registers
  logic [CNT_W-1:0]   var_count_r;
  logic [TABLE_W-1:0] type_table_r;

  // input register
  logic               in_valid_r;
  logic [BYTE_W-1:0]  in_byte_r;

  // run state
  tbr_state_t         state_r;
  tbr_state_t         state_nxt;

  // result register
  logic               out_valid_r;
  tbr_result_t        res_r;
  tbr_result_t        res_nxt;

  logic               out_free;
  logic               advance;

  // the result register is free when empty or being drained this cycle
  assign out_free  = !out_valid_r || out_tready;
  assign advance   = in_valid_r && out_free;
  assign in_tready = !in_valid_r || out_free;
  assign cfg_ready = 1'b1;

  // config writes; clamp the count once here
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      var_count_r  <= '0;
      type_table_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        CFG_VARIABLE_COUNT: var_count_r  <= clamp_count(cfg_data[CNT_W-1:0]);
        CFG_TYPE_TABLE:     type_table_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // input stage: hold the byte until the result register takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
    end
  end

  tbr_step u_step (
    .state      (state_r),
    .rx_byte    (in_byte_r),
    .var_count  (var_count_r),
    .type_table (type_table_r),
    .state_nxt  (state_nxt),
    .result     (res_nxt)
  );

  // advance the run state only when the byte moves into the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = res_r.write_valid;
  assign out_tdata  = {6'b0, res_r.tuning_busy, res_r.stop_flag, res_r.motor_off,
                       res_r.ack_seen, res_r.write_data, res_r.byte_offset,
                       res_r.var_index};

  `TBR_ASSERT_ALWAYS(a_one_event, !out_valid_r ||
    $onehot0({res_r.write_valid, res_r.ack_seen, res_r.motor_off}),
    "write, acknowledge and stop flagged together")

  `TBR_ASSERT_ALWAYS(a_idle_fields_zero, !out_valid_r || res_r.write_valid ||
    (res_r.var_index == '0 && res_r.byte_offset == '0 && res_r.write_data == '0),
    "write fields nonzero on a result without a write")

  `TBR_ASSERT_NEXT(a_state_holds, !advance, $stable(state_r),
    "run state changed without a byte advancing")

  `TBR_ASSERT_NEXT(a_stop_toggles, advance && res_nxt.motor_off,
    state_r.stop_state != $past(state_r.stop_state),
    "stop byte did not toggle the stop state")

  `TBR_ASSERT_NEXT(a_busy_matches, advance,
    res_r.tuning_busy == state_r.tuning_active,
    "reported busy differs from the run state")

endmodule
